>>> sv/obpe_pkg.sv
// Shared constants, codes and types of the bucket-pair eviction block.
`default_nettype none
package obpe_pkg;

    localparam int SLOTS_DEF   = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam int ID_W       = 32;
    localparam int LEAF_W     = 20;
    localparam int LEVEL_W    = 5;
    localparam int NODE_W     = 20;
    localparam int LCNT_W     = 21;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int BKT_W      = 2;
    localparam int SLOT_W     = 4;

    // Child heap indices and subtree bounds
    localparam int CHILD_W = NODE_W + 1;
    localparam int FIRST_W = 33;
    localparam int LB_W    = 43;

    localparam logic [CFG_IDX_W-1:0] REG_PARENT_LEVEL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_NODE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUMMY_ID     = 4'd3;

    localparam logic [LCNT_W-1:0] LEAF_COUNT_RST = 21'h100000;
    localparam logic [ID_W-1:0]   DUMMY_ID_RST   = 32'hFFFF_FFFF;

    typedef enum logic [BKT_W-1:0] {
        BKT_PARENT = 2'd0,
        BKT_LEFT   = 2'd1,
        BKT_RIGHT  = 2'd2
    } bucket_t;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DUMMY,
        CLS_KEEP,
        CLS_LEFT,
        CLS_RIGHT
    } slot_class_t;

    typedef enum logic [2:0] {
        F_LOAD,
        F_SETUP1,
        F_SETUP2,
        F_SETUP3,
        F_SETUP4,
        F_SWEEP
    } front_state_t;

    typedef enum logic [1:0] {
        B_LOAD,
        B_SCAN,
        B_OUT
    } back_state_t;

    function automatic bucket_t next_bucket(input bucket_t b);
        bucket_t r;
        unique case (b)
            BKT_PARENT: r = BKT_LEFT;
            BKT_LEFT:   r = BKT_RIGHT;
            default:    r = BKT_PARENT;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/obpe_front.sv
// Front end: configuration registers, slot loading and per-slot classification.
`default_nettype none
module obpe_front #(
    parameter int SLOTS = obpe_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [obpe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [obpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             push,
    output logic                             full,
    input  logic [obpe_pkg::ID_W-1:0]        slot_id,
    input  logic [obpe_pkg::LEAF_W-1:0]      leaf_label,
    output logic                             q_push,
    output obpe_pkg::slot_class_t            q_class,
    input  logic                             q_full
);
    import obpe_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

    logic [LEVEL_W-1:0] level_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [LCNT_W-1:0]  lcnt_reg;
    logic [ID_W-1:0]    dummy_reg;

    logic [ID_W-1:0]   ids_reg [3][SLOTS];
    logic [LEAF_W-1:0] leaves_reg [SLOTS];

    front_state_t state_reg, state_next;
    bucket_t      fb_reg;
    logic [SW-1:0] fs_reg;

    logic [LCNT_W-1:0]  step_reg;
    logic [CHILD_W-1:0] offl_reg;
    logic               vl_reg, vr_reg;
    logic [LB_W-1:0]    lbl_reg, hil_reg, lbr_reg, hir_reg;

    logic [5:0]         lvl;
    logic [FIRST_W-1:0] first;
    logic [CHILD_W-1:0] cl;
    logic [CHILD_W:0]   cr;
    logic [LCNT_W-1:0]  step;

    logic              accept, at_last, advance;
    logic [ID_W-1:0]   sid;
    logic [LB_W-1:0]   lf;
    logic              in_l, in_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            node_reg  <= '0;
            lcnt_reg  <= LEAF_COUNT_RST;
            dummy_reg <= DUMMY_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PARENT_LEVEL: level_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_PARENT_NODE:  node_reg  <= cfg_wdata[NODE_W-1:0];
                REG_LEAF_COUNT:   lcnt_reg  <= cfg_wdata[LCNT_W-1:0];
                REG_DUMMY_ID:     dummy_reg <= cfg_wdata[ID_W-1:0];
                default: ;
            endcase
        end
    end

    // Subtree bounds of both children
    assign lvl   = 6'(level_reg) + 6'd1;
    assign first = (FIRST_W'(1) << lvl) - FIRST_W'(1);
    assign step  = lcnt_reg >> lvl;
    assign cl    = {node_reg, 1'b1};
    assign cr    = (CHILD_W + 1)'(cl) + (CHILD_W + 1)'(1);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_SETUP1:
            begin
                step_reg <= step;
                offl_reg <= cl - first[CHILD_W-1:0];
                vl_reg   <= (FIRST_W'(cl) >= first) && (step != '0);
                vr_reg   <= (FIRST_W'(cr) >= first) && (step != '0);
            end
            F_SETUP2:
            begin
                lbl_reg <= LB_W'(offl_reg * step_reg);
            end
            F_SETUP3:
            begin
                hil_reg <= lbl_reg + LB_W'(step_reg);
                lbr_reg <= vl_reg ? (lbl_reg + LB_W'(step_reg)) : '0;
            end
            F_SETUP4:
            begin
                hir_reg <= lbr_reg + LB_W'(step_reg);
            end
            default: ;
        endcase
    end

    assign accept  = push && !full;
    assign at_last = (fb_reg == BKT_RIGHT) && (fs_reg == SLOT_LAST);
    assign advance = accept || q_push;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ids_reg[fb_reg][fs_reg] <= slot_id;
            if (fb_reg == BKT_PARENT)
            begin
                leaves_reg[fs_reg] <= leaf_label;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_LOAD;
            fb_reg    <= BKT_PARENT;
            fs_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
            begin
                if (fs_reg == SLOT_LAST)
                begin
                    fs_reg <= '0;
                    fb_reg <= next_bucket(fb_reg);
                end
                else
                begin
                    fs_reg <= fs_reg + SW'(1);
                end
            end
        end
    end

    // Classification of the slot under the sweep pointer
    assign sid  = ids_reg[fb_reg][fs_reg];
    assign lf   = LB_W'(leaves_reg[fs_reg]);
    assign in_l = vl_reg && (lf >= lbl_reg) && (lf < hil_reg);
    assign in_r = vr_reg && (lf >= lbr_reg) && (lf < hir_reg);

    always_comb
    begin
        if (fb_reg == BKT_PARENT)
        begin
            if (sid < dummy_reg)
            begin
                if (in_l)
                begin
                    q_class = CLS_LEFT;
                end
                else if (in_r)
                begin
                    q_class = CLS_RIGHT;
                end
                else
                begin
                    q_class = CLS_KEEP;
                end
            end
            else
            begin
                q_class = CLS_OTHER;
            end
        end
        else
        begin
            q_class = (sid == dummy_reg) ? CLS_DUMMY : CLS_OTHER;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        full       = (state_reg != F_LOAD);
        q_push     = (state_reg == F_SWEEP) && !q_full;
        unique case (state_reg)
            F_LOAD:   if (accept && at_last) state_next = F_SETUP1;
            F_SETUP1: state_next = F_SETUP2;
            F_SETUP2: state_next = F_SETUP3;
            F_SETUP3: state_next = F_SETUP4;
            F_SETUP4: state_next = F_SWEEP;
            F_SWEEP:  if (q_push && at_last) state_next = F_LOAD;
            default:  state_next = F_LOAD;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/obpe_queue.sv
// Short queue of slot classes between the front and back ends.
`default_nettype none
module obpe_queue #(
    parameter int DEPTH = obpe_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  obpe_pkg::slot_class_t din,
    output logic                  full,
    input  logic                  pop,
    output obpe_pkg::slot_class_t dout,
    output logic                  empty
);
    import obpe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    slot_class_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/obpe_back.sv
// Back end: gathers slot classes, runs the eviction scan and emits the slot mapping.
`default_nettype none
module obpe_back #(
    parameter int SLOTS = obpe_pkg::SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          q_pop,
    input  obpe_pkg::slot_class_t         q_class,
    input  logic                          q_empty,
    input  logic                          pop,
    output logic                          empty,
    output logic [obpe_pkg::BKT_W-1:0]    dest_bucket,
    output logic [obpe_pkg::SLOT_W-1:0]   dest_slot,
    output logic [obpe_pkg::BKT_W-1:0]    src_bucket,
    output logic [obpe_pkg::SLOT_W-1:0]   src_slot,
    output logic                          parent_full,
    output logic                          last
);
    import obpe_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

    back_state_t   state_reg, state_next;
    bucket_t       lb_reg;
    logic [SW-1:0] ls_reg;
    logic [SW-1:0] sc_reg;
    bucket_t       ob_reg;
    logic [SW-1:0] os_reg;

    slot_class_t   pcls_reg [SLOTS];
    logic [SLOTS-1:0] dmask_l_reg, dmask_r_reg;
    logic [SLOTS-1:0] pmoved_reg, cmoved_l_reg, cmoved_r_reg;
    bucket_t       pside_reg [SLOTS];
    logic [SW-1:0] pslot_reg [SLOTS];
    logic [SW-1:0] clsrc_reg [SLOTS];
    logic [SW-1:0] crsrc_reg [SLOTS];
    logic          full_reg;

    logic          ovld_reg;
    bucket_t       db_reg, sb_reg;
    logic [SW-1:0] ds_reg, ss_reg;
    logic          pfull_reg, last_reg;

    logic          ld_last, out_last, adv, out_take;
    slot_class_t   cur;
    logic          go_l, go_r, hit, do_move;
    logic [SLOTS-1:0] mask;
    logic [SW-1:0] j;
    bucket_t       src_b;
    logic [SW-1:0] src_s;

    assign ld_last  = (lb_reg == BKT_RIGHT) && (ls_reg == SLOT_LAST);
    assign out_last = (ob_reg == BKT_RIGHT) && (os_reg == SLOT_LAST);
    assign out_take = pop && ovld_reg;
    assign adv      = (state_reg == B_OUT) && (!ovld_reg || pop);

    // Scan step over one parent slot
    assign cur     = pcls_reg[sc_reg];
    assign go_l    = (cur == CLS_LEFT);
    assign go_r    = (cur == CLS_RIGHT);
    assign mask    = go_r ? dmask_r_reg : dmask_l_reg;
    assign do_move = (go_l || go_r) && hit;

    always_comb begin
        hit = 1'b0;
        j   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (mask[k]) begin
                hit = 1'b1;
                j   = SW'(k);
            end
        end
    end

    always_comb begin
        unique case (ob_reg)
            BKT_PARENT:
            begin
                src_b = pmoved_reg[os_reg] ? pside_reg[os_reg] : BKT_PARENT;
                src_s = pmoved_reg[os_reg] ? pslot_reg[os_reg] : os_reg;
            end
            BKT_LEFT:
            begin
                src_b = cmoved_l_reg[os_reg] ? BKT_PARENT : BKT_LEFT;
                src_s = cmoved_l_reg[os_reg] ? clsrc_reg[os_reg] : os_reg;
            end
            BKT_RIGHT:
            begin
                src_b = cmoved_r_reg[os_reg] ? BKT_PARENT : BKT_RIGHT;
                src_s = cmoved_r_reg[os_reg] ? crsrc_reg[os_reg] : os_reg;
            end
            default:
            begin
                src_b = BKT_PARENT;
                src_s = os_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = (state_reg == B_LOAD) && !q_empty;
        unique case (state_reg)
            B_LOAD: if (q_pop && ld_last) state_next = B_SCAN;
            B_SCAN: if (sc_reg == SLOT_LAST) state_next = B_OUT;
            B_OUT:  if (adv && out_last) state_next = B_LOAD;
            default: state_next = B_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= B_LOAD;
            lb_reg       <= BKT_PARENT;
            ls_reg       <= '0;
            sc_reg       <= '0;
            ob_reg       <= BKT_PARENT;
            os_reg       <= '0;
            pmoved_reg   <= '0;
            cmoved_l_reg <= '0;
            cmoved_r_reg <= '0;
            full_reg     <= 1'b0;
            ovld_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                if (ls_reg == SLOT_LAST) begin
                    ls_reg <= '0;
                    lb_reg <= next_bucket(lb_reg);
                end else begin
                    ls_reg <= ls_reg + SW'(1);
                end
                if (ld_last) begin
                    pmoved_reg   <= '0;
                    cmoved_l_reg <= '0;
                    cmoved_r_reg <= '0;
                    full_reg     <= 1'b1;
                    sc_reg       <= '0;
                end
            end
            if (state_reg == B_SCAN) begin
                sc_reg <= (sc_reg == SLOT_LAST) ? '0 : sc_reg + SW'(1);
                if (cur == CLS_OTHER || do_move) begin
                    full_reg <= 1'b0;
                end
                if (do_move) begin
                    pmoved_reg[sc_reg] <= 1'b1;
                    if (go_r) begin
                        cmoved_r_reg[j] <= 1'b1;
                    end else begin
                        cmoved_l_reg[j] <= 1'b1;
                    end
                end
                if (sc_reg == SLOT_LAST) begin
                    ob_reg <= BKT_PARENT;
                    os_reg <= '0;
                end
            end
            if (adv) begin
                ovld_reg <= 1'b1;
                if (os_reg == SLOT_LAST) begin
                    os_reg <= '0;
                    ob_reg <= next_bucket(ob_reg);
                end else begin
                    os_reg <= os_reg + SW'(1);
                end
            end else if (out_take) begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            unique case (lb_reg)
                BKT_PARENT: pcls_reg[ls_reg] <= q_class;
                BKT_LEFT:   dmask_l_reg[ls_reg] <= (q_class == CLS_DUMMY);
                BKT_RIGHT:  dmask_r_reg[ls_reg] <= (q_class == CLS_DUMMY);
                default: ;
            endcase
        end
        if ((state_reg == B_SCAN) && do_move) begin
            pside_reg[sc_reg] <= go_r ? BKT_RIGHT : BKT_LEFT;
            pslot_reg[sc_reg] <= j;
            if (go_r) begin
                dmask_r_reg[j] <= 1'b0;
                crsrc_reg[j]   <= sc_reg;
            end else begin
                dmask_l_reg[j] <= 1'b0;
                clsrc_reg[j]   <= sc_reg;
            end
        end
        if (adv) begin
            db_reg    <= ob_reg;
            ds_reg    <= os_reg;
            sb_reg    <= src_b;
            ss_reg    <= src_s;
            pfull_reg <= full_reg;
            last_reg  <= out_last;
        end
    end

    assign empty       = !ovld_reg;
    assign dest_bucket = db_reg;
    assign dest_slot   = SLOT_W'(ds_reg);
    assign src_bucket  = sb_reg;
    assign src_slot    = SLOT_W'(ss_reg);
    assign parent_full = pfull_reg;
    assign last        = last_reg;

    a_swap_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pmoved_reg) == ($countones(cmoved_l_reg) + $countones(cmoved_r_reg)))
        else $error("moved parent and child slot counts disagree");

    a_moved_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (pmoved_reg != '0) |-> !full_reg)
        else $error("parent flagged full after a block left it");

    a_full_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !last_reg) |=> (ovld_reg && (pfull_reg == $past(pfull_reg))))
        else $error("parent_full changed within a run");

endmodule
`default_nettype wire

>>> sv/oram_bucket_pair_eviction_top.sv
// Top level of the bucket-pair eviction block: front end, class queue and back end.
//
// Input channel (push/full): one transaction per bucket slot, parent slots first,
// then the left child, then the right child, 3*SLOTS transactions per run.
// leaf_label is taken for parent slots only. full is high while the front end
// works out the subtree bounds and classifies the slots of a finished run.
// Result channel (empty/pop): after the last slot of a run the block delivers
// 3*SLOTS transactions, one per destination slot in bucket then slot order,
// giving the source of its content; last marks the final one.
// Configuration: cfg_we/cfg_addr/cfg_wdata write parent_level, parent_node,
// leaf_count and dummy_id (indices 0 to 3); other indices are dropped.
// Order of work: after the last slot is accepted the front end computes the subtree
// bounds in its setup states and classifies the slots into the queue; the back end
// gathers the classes, scans the parent slots and registers the first result.
// Per run the back end gathers 3*SLOTS classes, scans SLOTS parent slots and emits
// 3*SLOTS results, and it takes the classes of the next run only after its last
// result is registered. Loading of the next run overlaps the back end.
// Reset clears all control state and restores the register defaults; a stalled
// pop holds the current result and the back end waits, then the queue fills
// and full holds off the next run.
`default_nettype none
module oram_bucket_pair_eviction_top #(
    parameter int SLOTS = obpe_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [obpe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [obpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             push,
    output logic                             full,
    input  logic [obpe_pkg::ID_W-1:0]        slot_id,
    input  logic [obpe_pkg::LEAF_W-1:0]      leaf_label,
    output logic                             empty,
    input  logic                             pop,
    output logic [obpe_pkg::BKT_W-1:0]       dest_bucket,
    output logic [obpe_pkg::SLOT_W-1:0]      dest_slot,
    output logic [obpe_pkg::BKT_W-1:0]       src_bucket,
    output logic [obpe_pkg::SLOT_W-1:0]      src_slot,
    output logic                             parent_full,
    output logic                             last
);
    import obpe_pkg::*;

    logic        q_push, q_full, q_pop, q_empty;
    slot_class_t q_din, q_dout;

    obpe_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .slot_id    (slot_id),
        .leaf_label (leaf_label),
        .q_push     (q_push),
        .q_class    (q_din),
        .q_full     (q_full)
    );

    obpe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    obpe_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_pop       (q_pop),
        .q_class     (q_dout),
        .q_empty     (q_empty),
        .pop         (pop),
        .empty       (empty),
        .dest_bucket (dest_bucket),
        .dest_slot   (dest_slot),
        .src_bucket  (src_bucket),
        .src_slot    (src_slot),
        .parent_full (parent_full),
        .last        (last)
    );

endmodule
`default_nettype wire
